### rtl/indexed_list_engine_macros.svh
// Assertion helpers shared by the list engine RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Sizes, stream layouts and request codes of the indexed list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ile_pkg;

  // Number of list entries.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream payload.
  localparam int unsigned KIND_W = 4;
  localparam int unsigned IDX_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned LEN_W  = 7;

  // Width used to compare request indices against the fill count.
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [VAL_W-1:0] VAL_NEG_ONE = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 4'd0,
    KIND_INSERT   = 4'd1,
    KIND_REMOVE   = 4'd2,
    KIND_GET      = 4'd3,
    KIND_SET      = 4'd4,
    KIND_CONTAINS = 4'd5,
    KIND_LAST_IDX = 4'd6,
    KIND_SWAP     = 4'd7,
    KIND_CLEAR    = 4'd8
  } kind_e;

endpackage

### rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed words in one simple dual-port memory, driven by a
// read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Append, set, clear and refused requests go straight to the reply step; get
// waits for the memory read; swap reads both entries and writes them back;
// insert and remove shift entries unless at the list end; contains and last
// index scan and stop at the first match. One request is in work at a time;
// the single memory read port, one entry per cycle, paces shifts and searches.
// Reset clears the fill count and control; memory contents are not cleared.
`timescale 1ns / 1ps

`include "indexed_list_engine_macros.svh"

module indexed_list_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [6:0] index, [13:7] second_index, [45:14] value, [47:46] zero
  input  logic [ile_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [3:0] kind
  input  logic [ile_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] read_value, [37:32] position, [44:38] length_now, [47:45] zero
  output logic [ile_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] ok
  output logic                           m_axis_tuser
);

  localparam int unsigned AW = ile_pkg::ADDR_W;
  localparam int unsigned CW = ile_pkg::CNT_W;
  localparam int unsigned MW = ile_pkg::CMP_W;
  localparam int unsigned VW = ile_pkg::VAL_W;
  localparam int unsigned IW = ile_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_SHIFT_DN,
    ST_GET_WAIT,
    ST_SCAN,
    ST_SWAP_RD2,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_REPLY
  } state_e;

  state_e                        state_q, state_d;
  ile_pkg::kind_e                kind_q, kind_d;
  logic [IW-1:0]                 idx_q, idx_d;
  logic [IW-1:0]                 idx2_q, idx2_d;
  logic [VW-1:0]                 val_q, val_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic [CW-1:0]                 fill_q, fill_d;
  logic                          ok_q, ok_d;
  logic [VW-1:0]                 rd_q, rd_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic                          m_valid_q, m_valid_d;
  logic [ile_pkg::M_TDATA_W-1:0] m_data_q, m_data_d;
  logic                          m_user_q, m_user_d;

  // List storage with one write port and one registered read port.
  logic [VW-1:0] mem [ile_pkg::CAPACITY];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata, mem_rdata_q;

  logic [IW-1:0] in_idx, in_idx2;
  logic [VW-1:0] in_val;
  logic [MW-1:0] fill_x, in_idx_x, in_idx2_x;
  logic [MW-1:0] len_x, pos_x;
  logic [AW-1:0] last_addr;
  logic          full, accept;

  assign in_idx  = s_axis_tdata[IW-1:0];
  assign in_idx2 = s_axis_tdata[2*IW-1:IW];
  assign in_val  = s_axis_tdata[2*IW+VW-1:2*IW];

  assign fill_x    = MW'(fill_q);
  assign in_idx_x  = MW'(in_idx);
  assign in_idx2_x = MW'(in_idx2);
  assign full      = (fill_q == CW'(ile_pkg::CAPACITY));
  assign last_addr = AW'(fill_q - CW'(1));
  assign len_x     = MW'(fill_q);
  assign pos_x     = MW'(pos_q);

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    idx2_d    = idx2_q;
    val_d     = val_q;
    ptr_d     = ptr_q;
    fill_d    = fill_q;
    ok_d      = ok_q;
    rd_d      = rd_q;
    pos_d     = pos_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d  = ile_pkg::kind_e'(s_axis_tuser);
          idx_d   = in_idx;
          idx2_d  = in_idx2;
          val_d   = in_val;
          ok_d    = 1'b0;
          rd_d    = '0;
          pos_d   = '0;
          state_d = ST_REPLY;
          unique case (ile_pkg::kind_e'(s_axis_tuser))
            ile_pkg::KIND_APPEND: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(fill_q);
                mem_wdata = in_val;
                fill_d    = fill_q + CW'(1);
                ok_d      = 1'b1;
              end
            end
            ile_pkg::KIND_INSERT: begin
              if (!full && in_idx_x <= fill_x) begin
                if (in_idx_x == fill_x) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(in_idx);
                  mem_wdata = in_val;
                  fill_d    = fill_q + CW'(1);
                  ok_d      = 1'b1;
                end else begin
                  // Walk down from the top entry, moving each one up a slot.
                  mem_re    = 1'b1;
                  mem_raddr = last_addr;
                  ptr_d     = last_addr;
                  state_d   = ST_SHIFT_UP;
                end
              end
            end
            ile_pkg::KIND_REMOVE: begin
              if (in_idx_x < fill_x) begin
                if (AW'(in_idx) == last_addr) begin
                  fill_d = fill_q - CW'(1);
                  ok_d   = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = AW'(in_idx) + AW'(1);
                  ptr_d     = AW'(in_idx) + AW'(1);
                  state_d   = ST_SHIFT_DN;
                end
              end
            end
            ile_pkg::KIND_GET: begin
              if (in_idx_x < fill_x) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_idx);
                state_d   = ST_GET_WAIT;
              end else begin
                rd_d = ile_pkg::VAL_NEG_ONE;
              end
            end
            ile_pkg::KIND_SET: begin
              if (in_idx_x < fill_x) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_idx);
                mem_wdata = in_val;
                ok_d      = 1'b1;
              end
            end
            ile_pkg::KIND_CONTAINS: begin
              if (fill_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = ST_SCAN;
              end
            end
            ile_pkg::KIND_LAST_IDX: begin
              if (fill_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = last_addr;
                ptr_d     = last_addr;
                state_d   = ST_SCAN;
              end
            end
            ile_pkg::KIND_SWAP: begin
              if (in_idx_x < fill_x && in_idx2_x < fill_x) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_idx);
                state_d   = ST_SWAP_RD2;
              end
            end
            ile_pkg::KIND_CLEAR: begin
              fill_d = '0;
              ok_d   = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_SHIFT_UP: begin
        // Read data holds the entry at ptr_q; it moves to ptr_q + 1.
        mem_we    = 1'b1;
        mem_waddr = ptr_q + AW'(1);
        mem_wdata = mem_rdata_q;
        if (ptr_q == AW'(idx_q)) begin
          state_d = ST_INS_WR;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - AW'(1);
          ptr_d     = ptr_q - AW'(1);
        end
      end

      ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q);
        mem_wdata = val_q;
        fill_d    = fill_q + CW'(1);
        ok_d      = 1'b1;
        state_d   = ST_REPLY;
      end

      ST_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        mem_wdata = mem_rdata_q;
        if (ptr_q == last_addr) begin
          fill_d  = fill_q - CW'(1);
          ok_d    = 1'b1;
          state_d = ST_REPLY;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end
      end

      ST_GET_WAIT: begin
        rd_d    = mem_rdata_q;
        ok_d    = 1'b1;
        state_d = ST_REPLY;
      end

      ST_SCAN: begin
        if (mem_rdata_q == val_q) begin
          ok_d    = 1'b1;
          pos_d   = (kind_q == ile_pkg::KIND_LAST_IDX) ? ptr_q : '0;
          state_d = ST_REPLY;
        end else if (kind_q == ile_pkg::KIND_CONTAINS) begin
          if (ptr_q == last_addr) begin
            state_d = ST_REPLY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_q + AW'(1);
            ptr_d     = ptr_q + AW'(1);
          end
        end else begin
          if (ptr_q == '0) begin
            state_d = ST_REPLY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ptr_q - AW'(1);
            ptr_d     = ptr_q - AW'(1);
          end
        end
      end

      ST_SWAP_RD2: begin
        // The first entry arrives now; the request value is no longer needed.
        val_d     = mem_rdata_q;
        mem_re    = 1'b1;
        mem_raddr = AW'(idx2_q);
        state_d   = ST_SWAP_WR1;
      end

      ST_SWAP_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q);
        mem_wdata = mem_rdata_q;
        state_d   = ST_SWAP_WR2;
      end

      ST_SWAP_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx2_q);
        mem_wdata = val_q;
        ok_d      = 1'b1;
        state_d   = ST_REPLY;
      end

      ST_REPLY: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = ok_q;
          m_data_d  = {3'b000, len_x[ile_pkg::LEN_W-1:0],
                       pos_x[ile_pkg::POS_W-1:0], rd_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kind_q    <= ile_pkg::KIND_APPEND;
      idx_q     <= '0;
      idx2_q    <= '0;
      val_q     <= '0;
      ptr_q     <= '0;
      fill_q    <= '0;
      ok_q      <= 1'b0;
      rd_q      <= '0;
      pos_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      idx_q     <= idx_d;
      idx2_q    <= idx2_d;
      val_q     <= val_d;
      ptr_q     <= ptr_d;
      fill_q    <= fill_d;
      ok_q      <= ok_d;
      rd_q      <= rd_d;
      pos_q     <= pos_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  `ILE_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(ile_pkg::CAPACITY),
                  "fill count above capacity")
  `ILE_ASSERT_NEXT(a_reply_holds, state_q == ST_REPLY && m_valid_q && !m_axis_tready,
                   state_q == ST_REPLY, "result dropped while output stalled")
  `ILE_ASSERT_NEXT(a_scan_keeps_fill, state_q == ST_SCAN, $stable(fill_q),
                   "fill count changed during a search")
  `ILE_ASSERT_NOW(a_result_from_reply, $rose(m_valid_q), $past(state_q) == ST_REPLY,
                  "result raised outside the reply step")

endmodule
